@@ sv/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  // Decoder modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_END_ESCAPE   = 3'd1;
  localparam logic [2:0] ERR_END_HEX      = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd4;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd5;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // Decoder state
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  hex_count;
    logic [15:0] code_point;
  } dec_state_t;

  // All results caused by one request; cnt is 0..3, byte 0 goes out first.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0]      err;
  } res_group_t;

endpackage
`default_nettype wire

@@ sv/json_string_unescape_utf8_core.sv @@
// JSON string unescaper with UTF-8 output.
// Input channel (in_*): one text byte per request in in_tdata[7:0]; in_tlast
// set means the text has ended and the data byte is ignored. A string starts
// at its opening quote; escapes are decoded and \uXXXX becomes 1 to 3 UTF-8
// bytes. Output channel (out_*): one result per request; out_tuser is the
// kind (decoded byte, string closed, error), out_tdata carries the byte and
// the error code, out_tlast marks the final result caused by one input byte.
// With the queue empty, a result appears on the output the cycle after its
// input byte is accepted.
// Throughput: one input byte per cycle unless stalled. A three-byte \u group
// followed at once by a byte that gives a result stalls the input while the
// group's tail drains; one- and two-byte groups never stall a ready receiver.
// The decoder state advances as each byte is accepted; results sit in a
// two-group queue, at most one group per input byte, read out byte by byte.
// When the receiver stalls the queue fills and in_tready drops once both
// groups are held and the head is not finishing this cycle.
// Reset (rst_n low, synchronous) empties the queue and returns the decoder
// to waiting for an opening quote.
`default_nettype none
module json_string_unescape_utf8_core
  import jsu_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [7:0]  in_tdata,    // [7:0] data_byte
  input  wire        in_tlast,    // at_end
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0] out_tuser,   // [1:0] kind
  output logic       out_tlast    // last result of this input byte
);

  dec_state_t st_r, st_nxt;
  res_group_t grp;
  logic       accept, full, pop_grp;

  // Decoder state advances on every accepted request.
  jsu_step u_step (
    .st        (st_r),
    .data_byte (in_tdata),
    .at_end    (in_tlast),
    .st_nxt    (st_nxt),
    .grp       (grp)
  );

  // Accept while a group slot is free or the head group leaves this cycle.
  assign in_tready = !full || pop_grp;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  jsu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept && (grp.cnt != 2'd0)),
    .push_grp   (grp),
    .full       (full),
    .pop_grp    (pop_grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

@@ sv/jsu_step.sv @@
`default_nettype none
module jsu_step
  import jsu_pkg::*;
(
  input  wire dec_state_t st,
  input  wire [7:0]       data_byte,
  input  wire             at_end,
  output dec_state_t      st_nxt,
  output res_group_t      grp
);

  logic [4:0]  hex_d;   // bit 4 flags a non-hex byte
  logic [15:0] cp_new;

  always_comb begin
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_d = {1'b0, data_byte[3:0]};
    end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
      hex_d = {1'b0, data_byte[3:0] + 4'd9};
    end else begin
      hex_d = 5'h10;
    end
  end

  assign cp_new = {st.code_point[11:0], hex_d[3:0]};

  always_comb begin
    st_nxt = st;
    grp    = '0;
    case (st.mode)
      MODE_STR: begin
        if (at_end) begin
          st_nxt   = '0;
          grp.cnt  = 2'd1;
          grp.kind = KIND_ERROR;
          grp.err  = ERR_UNTERMINATED;
        end else if (data_byte == CH_QUOTE) begin
          st_nxt.mode = MODE_IDLE;
          grp.cnt     = 2'd1;
          grp.kind    = KIND_CLOSE;
        end else if (data_byte == CH_BSLASH) begin
          st_nxt.mode = MODE_ESC;
        end else begin
          grp.cnt      = 2'd1;
          grp.bytes[0] = data_byte;
        end
      end
      MODE_ESC: begin
        st_nxt.mode = MODE_STR;
        grp.cnt     = 2'd1;
        if (at_end) begin
          st_nxt   = '0;
          grp.kind = KIND_ERROR;
          grp.err  = ERR_END_ESCAPE;
        end else begin
          case (data_byte)
            CH_QUOTE:  grp.bytes[0] = CH_QUOTE;
            CH_BSLASH: grp.bytes[0] = CH_BSLASH;
            CH_SLASH:  grp.bytes[0] = CH_SLASH;
            CH_B:      grp.bytes[0] = 8'h08;
            CH_F:      grp.bytes[0] = 8'h0C;
            CH_N:      grp.bytes[0] = 8'h0A;
            CH_R:      grp.bytes[0] = 8'h0D;
            CH_T:      grp.bytes[0] = 8'h09;
            CH_U: begin
              st_nxt  = '{mode: MODE_HEX, hex_count: 2'd0, code_point: 16'd0};
              grp.cnt = 2'd0;
            end
            default: begin
              st_nxt   = '0;
              grp.kind = KIND_ERROR;
              grp.err  = ERR_UNKNOWN_ESC;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (at_end || hex_d[4]) begin
          st_nxt   = '0;
          grp.cnt  = 2'd1;
          grp.kind = KIND_ERROR;
          grp.err  = at_end ? ERR_END_HEX : ERR_BAD_HEX;
        end else if (st.hex_count != 2'd3) begin
          st_nxt.hex_count  = st.hex_count + 2'd1;
          st_nxt.code_point = cp_new;
        end else begin
          st_nxt = '{mode: MODE_STR, hex_count: 2'd0, code_point: 16'd0};
          if (cp_new < 16'h0080) begin
            grp.cnt      = 2'd1;
            grp.bytes[0] = cp_new[7:0];
          end else if (cp_new < 16'h0800) begin
            grp.cnt      = 2'd2;
            grp.bytes[0] = {3'b110, cp_new[10:6]};
            grp.bytes[1] = {2'b10, cp_new[5:0]};
          end else begin
            grp.cnt      = 2'd3;
            grp.bytes[0] = {4'b1110, cp_new[15:12]};
            grp.bytes[1] = {2'b10, cp_new[11:6]};
            grp.bytes[2] = {2'b10, cp_new[5:0]};
          end
        end
      end
      default: begin
        st_nxt.mode = MODE_IDLE;
        if (!at_end) begin
          if (data_byte == CH_QUOTE) begin
            st_nxt = '{mode: MODE_STR, hex_count: 2'd0, code_point: 16'd0};
          end else begin
            st_nxt   = '0;
            grp.cnt  = 2'd1;
            grp.kind = KIND_ERROR;
            grp.err  = ERR_NO_QUOTE;
          end
        end
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/jsu_outq.sv @@
`default_nettype none
module jsu_outq
  import jsu_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  wire res_group_t push_grp,
  output logic            full,
  output logic            pop_grp,
  output logic            out_tvalid,
  input  wire             out_tready,
  output logic [15:0]     out_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]      out_tuser,   // [1:0] kind
  output logic            out_tlast
);

  res_group_t slot_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] sub_r;
  res_group_t head;
  logic       pop_item;

  assign head       = slot_r[rd_r];
  assign full       = (cnt_r == 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop_item   = out_tvalid && out_tready;
  assign out_tlast  = (sub_r == head.cnt - 2'd1);
  assign pop_grp    = pop_item && out_tlast;
  assign out_tdata  = {5'd0, head.err, head.bytes[sub_r]};
  assign out_tuser  = head.kind;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop_grp) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop_grp) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
      sub_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop_grp) begin
        rd_r  <= ~rd_r;
        sub_r <= 2'd0;
      end else if (pop_item) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_grp;
  end

endmodule
`default_nettype wire
